// File: sv/c2s_pkg.sv
// shared types, constants and the arctangent table of the spherical angle block
package c2s_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int IN_W            = 16;
    localparam int AZ_W            = 16;
    localparam int ZEN_W           = 15;
    localparam int SQ_W            = 31;
    localparam int R2_W            = 32;

    localparam int ACC_BITS     = 24;
    localparam int ACC_W        = 34;
    localparam int CW           = 60;
    localparam int CORDIC_STEPS = 24;
    localparam int PREC_SHIFT   = 40;

    localparam int R_W         = 62;
    localparam int K_W         = 5;
    localparam int NORM_STAGES = 5;
    localparam int SQRT_BITS   = 31;
    localparam int REM_W       = 34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ROUND_SHIFT = ACC_BITS - ANGLE_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_DEG90  = ACC_W'(64'sd90 <<< ACC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_DEG180 = ACC_W'(64'sd180 <<< ACC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_DEG360 = ACC_W'(64'sd360 <<< ACC_BITS);
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (ACC_BITS - 1 - ANGLE_FRAC_BITS));
    localparam logic [ACC_W-1:0] OUT_DEG180 = ACC_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [ACC_W-1:0] OUT_DEG360 = ACC_W'(64'd360 << ANGLE_FRAC_BITS);

    localparam logic [AZ_W-1:0]  AZ_DEG90   = AZ_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [AZ_W-1:0]  AZ_DEG180  = AZ_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [AZ_W-1:0]  AZ_DEG270  = AZ_W'(64'd270 << ANGLE_FRAC_BITS);
    localparam logic [ZEN_W-1:0] ZEN_DEG90  = ZEN_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [ZEN_W-1:0] ZEN_DEG180 = ZEN_W'(64'd180 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
        logic                   az_fix_v;
        logic [AZ_W-1:0]        az_fix;
        logic                   zen_fix_v;
        logic [ZEN_W-1:0]       zen_fix;
    } tag_t;

    typedef struct packed {
        tag_t           tag;
        logic [SQ_W-1:0] xx;
        logic [SQ_W-1:0] yy;
    } item_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [ACC_W-1:0] atan_rom(input int unsigned i);
        logic signed [ACC_W-1:0] v;
        case (i)
            0:  v = ACC_W'(754974720);
            1:  v = ACC_W'(445687602);
            2:  v = ACC_W'(235489088);
            3:  v = ACC_W'(119537938);
            4:  v = ACC_W'(60000934);
            5:  v = ACC_W'(30029717);
            6:  v = ACC_W'(15018523);
            7:  v = ACC_W'(7509720);
            8:  v = ACC_W'(3754917);
            9:  v = ACC_W'(1877466);
            10: v = ACC_W'(938734);
            11: v = ACC_W'(469367);
            12: v = ACC_W'(234684);
            13: v = ACC_W'(117342);
            14: v = ACC_W'(58671);
            15: v = ACC_W'(29335);
            16: v = ACC_W'(14668);
            17: v = ACC_W'(7334);
            18: v = ACC_W'(3667);
            19: v = ACC_W'(1833);
            20: v = ACC_W'(917);
            21: v = ACC_W'(458);
            22: v = ACC_W'(229);
            23: v = ACC_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/c2s_vec_if.sv
// input channel: one vector word per handshake
interface c2s_vec_if;
    logic                              valid;
    logic                              ready;
    logic signed [c2s_pkg::IN_W-1:0]   vec_x;
    logic signed [c2s_pkg::IN_W-1:0]   vec_y;
    logic signed [c2s_pkg::IN_W-1:0]   vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// File: sv/c2s_ang_if.sv
// output channel: one angle pair word per handshake
interface c2s_ang_if;
    logic                         valid;
    logic                         ready;
    logic [c2s_pkg::AZ_W-1:0]     azimuth;
    logic [c2s_pkg::ZEN_W-1:0]    zenith;

    modport source (output valid, output azimuth, output zenith, input ready);
    modport sink   (input valid, input azimuth, input zenith, output ready);
endinterface

// File: sv/c2s_front.sv
// front stage: takes vector words, squares x and y, resolves the axis cases
module c2s_front (
    input  logic              clk,
    input  logic              rst_n,
    c2s_vec_if.sink           vec,
    output logic              push_valid,
    input  logic              push_ready,
    output c2s_pkg::item_t    push_item
);

    logic            front_valid_reg;
    c2s_pkg::item_t  item_reg;
    c2s_pkg::item_t  item_next;
    logic signed [c2s_pkg::R2_W-1:0] sx, sy, sqx, sqy;
    logic            x_zero, y_zero, z_zero, xy_zero;

    assign vec.ready  = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        sx      = c2s_pkg::R2_W'(vec.vec_x);
        sy      = c2s_pkg::R2_W'(vec.vec_y);
        sqx     = sx * sx;
        sqy     = sy * sy;
        x_zero  = (vec.vec_x == '0);
        y_zero  = (vec.vec_y == '0);
        z_zero  = (vec.vec_z == '0);
        xy_zero = x_zero && y_zero;

        item_next.tag.x     = vec.vec_x;
        item_next.tag.y     = vec.vec_y;
        item_next.tag.z     = vec.vec_z;
        item_next.xx        = sqx[c2s_pkg::SQ_W-1:0];
        item_next.yy        = sqy[c2s_pkg::SQ_W-1:0];

        item_next.tag.az_fix_v = x_zero || y_zero;
        if (xy_zero)
            item_next.tag.az_fix = '0;
        else if (y_zero)
            item_next.tag.az_fix = (vec.vec_x > 0) ? '0 : c2s_pkg::AZ_DEG180;
        else
            item_next.tag.az_fix = (vec.vec_y > 0) ? c2s_pkg::AZ_DEG90 : c2s_pkg::AZ_DEG270;

        item_next.tag.zen_fix_v = z_zero || xy_zero;
        if (xy_zero && !z_zero)
            item_next.tag.zen_fix = (vec.vec_z > 0) ? c2s_pkg::ZEN_DEG180 : '0;
        else
            item_next.tag.zen_fix = c2s_pkg::ZEN_DEG90;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (vec.ready)
            front_valid_reg <= vec.valid;
    end

    always_ff @(posedge clk)
    begin
        if (vec.ready && vec.valid)
            item_reg <= item_next;
    end

endmodule

// File: sv/c2s_queue.sv
// short queue between the front stage and the angle pipeline
module c2s_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  c2s_pkg::item_t    push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output c2s_pkg::item_t    pop_item
);

    c2s_pkg::item_t                 slot_reg [c2s_pkg::QUEUE_DEPTH];
    logic [c2s_pkg::QPTR_W-1:0]     wptr_reg, rptr_reg;
    logic [c2s_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != c2s_pkg::QCNT_W'(c2s_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= c2s_pkg::QCNT_W'(c2s_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != c2s_pkg::QCNT_W'(c2s_pkg::QUEUE_DEPTH)) |->
        (c2s_pkg::QPTR_W'(wptr_reg - rptr_reg) == count_reg[c2s_pkg::QPTR_W-1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: sv/c2s_back.sv
// angle pipeline: radius normalize, square root, twin vectoring cordic, rounding
module c2s_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  c2s_pkg::item_t    pop_item,
    c2s_ang_if.source         angles
);

    localparam int NS = c2s_pkg::NORM_STAGES;
    localparam int QS = c2s_pkg::SQRT_BITS;
    localparam int CS = c2s_pkg::CORDIC_STEPS;
    localparam int CW = c2s_pkg::CW;
    localparam int AW = c2s_pkg::ACC_W;

    logic adv;
    logic out_valid_reg;
    logic [c2s_pkg::AZ_W-1:0]  az_reg;
    logic [c2s_pkg::ZEN_W-1:0] zen_reg;

    assign adv          = !out_valid_reg || angles.ready;
    assign pop_ready    = adv;
    assign angles.valid   = out_valid_reg;
    assign angles.azimuth = az_reg;
    assign angles.zenith  = zen_reg;

    // sum of squares
    logic                       s0_valid_reg;
    c2s_pkg::tag_t              s0_tag_reg;
    logic [c2s_pkg::R2_W-1:0]   s0_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_tag_reg <= pop_item.tag;
            s0_r2_reg  <= {1'b0, pop_item.xx} + {1'b0, pop_item.yy};
        end
    end

    // normalize: shift left by pairs of bits until the top pair is nonzero
    logic                       n_valid_reg [NS];
    c2s_pkg::tag_t              n_tag_reg   [NS];
    logic [c2s_pkg::R_W-1:0]    n_r_reg     [NS];
    logic [c2s_pkg::K_W-1:0]    n_k_reg     [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_norm
        localparam int SH = 2 * (1 << (NS - 1 - j));
        logic                    v_in;
        c2s_pkg::tag_t           t_in;
        logic [c2s_pkg::R_W-1:0] r_in;
        logic [c2s_pkg::K_W-1:0] k_in;
        logic                    hit;

        if (j == 0)
        begin : g_first
            assign v_in = s0_valid_reg;
            assign t_in = s0_tag_reg;
            assign r_in = c2s_pkg::R_W'(s0_r2_reg);
            assign k_in = '0;
        end
        else
        begin : g_rest
            assign v_in = n_valid_reg[j-1];
            assign t_in = n_tag_reg[j-1];
            assign r_in = n_r_reg[j-1];
            assign k_in = n_k_reg[j-1];
        end

        assign hit = (r_in[c2s_pkg::R_W-1 -: SH] == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                n_valid_reg[j] <= 1'b0;
            else if (adv)
                n_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_tag_reg[j] <= t_in;
                n_r_reg[j]   <= hit ? (r_in << SH) : r_in;
                n_k_reg[j]   <= hit ? (k_in + c2s_pkg::K_W'(SH / 2)) : k_in;
            end
        end
    end

    // square root, one result bit per stage
    logic                          q_valid_reg [QS];
    c2s_pkg::tag_t                 q_tag_reg   [QS];
    logic [c2s_pkg::R_W-1:0]       q_v_reg     [QS];
    logic [c2s_pkg::REM_W-1:0]     q_rem_reg   [QS];
    logic [QS-1:0]                 q_res_reg   [QS];
    logic [c2s_pkg::K_W-1:0]       q_k_reg     [QS];

    for (genvar j = 0; j < QS; j++)
    begin : g_sqrt
        logic                        v_in;
        c2s_pkg::tag_t               t_in;
        logic [c2s_pkg::R_W-1:0]     val_in;
        logic [c2s_pkg::REM_W-1:0]   rem_in, rem_sh, trial;
        logic [QS-1:0]               res_in;
        logic [c2s_pkg::K_W-1:0]     k_in;
        logic                        fits;

        if (j == 0)
        begin : g_first
            assign v_in   = n_valid_reg[NS-1];
            assign t_in   = n_tag_reg[NS-1];
            assign val_in = n_r_reg[NS-1];
            assign rem_in = '0;
            assign res_in = '0;
            assign k_in   = n_k_reg[NS-1];
        end
        else
        begin : g_rest
            assign v_in   = q_valid_reg[j-1];
            assign t_in   = q_tag_reg[j-1];
            assign val_in = q_v_reg[j-1];
            assign rem_in = q_rem_reg[j-1];
            assign res_in = q_res_reg[j-1];
            assign k_in   = q_k_reg[j-1];
        end

        assign rem_sh = {rem_in[c2s_pkg::REM_W-3:0], val_in[c2s_pkg::R_W-1 -: 2]};
        assign trial  = c2s_pkg::REM_W'({res_in, 2'b01});
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_valid_reg[j] <= 1'b0;
            else if (adv)
                q_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_tag_reg[j] <= t_in;
                q_v_reg[j]   <= val_in << 2;
                q_rem_reg[j] <= fits ? (rem_sh - trial) : rem_sh;
                q_res_reg[j] <= {res_in[QS-2:0], fits};
                q_k_reg[j]   <= k_in;
            end
        end
    end

    // cordic load: both lanes start here
    logic                     l_valid_reg;
    c2s_pkg::tag_t            l_tag_reg;
    logic signed [CW-1:0]     l_ax_reg, l_ay_reg, l_zx_reg, l_zy_reg;
    logic signed [AW-1:0]     l_aa_reg, l_za_reg;
    logic signed [CW-1:0]     ld_x, ld_y, ld_z;
    logic                     ld_neg;

    always_comb
    begin
        ld_x   = CW'(q_tag_reg[QS-1].x);
        ld_y   = CW'(q_tag_reg[QS-1].y);
        ld_z   = CW'(q_tag_reg[QS-1].z);
        ld_neg = ld_x < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_valid_reg <= 1'b0;
        else if (adv)
            l_valid_reg <= q_valid_reg[QS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_tag_reg <= q_tag_reg[QS-1];
            l_ax_reg  <= (ld_neg ? -ld_x : ld_x) <<< c2s_pkg::PREC_SHIFT;
            l_ay_reg  <= (ld_neg ? -ld_y : ld_y) <<< c2s_pkg::PREC_SHIFT;
            l_aa_reg  <= ld_neg ? c2s_pkg::ACC_DEG180 : '0;
            l_zx_reg  <= CW'(q_res_reg[QS-1]);
            l_zy_reg  <= ld_z <<< q_k_reg[QS-1];
            l_za_reg  <= c2s_pkg::ACC_DEG90;
        end
    end

    // vectoring cordic, azimuth and elevation lanes side by side
    logic                     c_valid_reg [CS];
    c2s_pkg::tag_t            c_tag_reg   [CS];
    logic signed [CW-1:0]     c_ax_reg [CS], c_ay_reg [CS], c_zx_reg [CS], c_zy_reg [CS];
    logic signed [AW-1:0]     c_aa_reg [CS], c_za_reg [CS];

    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        logic                 v_in;
        c2s_pkg::tag_t        t_in;
        logic signed [CW-1:0] ax, ay, zx, zy;
        logic signed [AW-1:0] aa, za;
        logic signed [AW-1:0] rom;

        if (i == 0)
        begin : g_first
            assign v_in = l_valid_reg;
            assign t_in = l_tag_reg;
            assign ax = l_ax_reg;
            assign ay = l_ay_reg;
            assign aa = l_aa_reg;
            assign zx = l_zx_reg;
            assign zy = l_zy_reg;
            assign za = l_za_reg;
        end
        else
        begin : g_rest
            assign v_in = c_valid_reg[i-1];
            assign t_in = c_tag_reg[i-1];
            assign ax = c_ax_reg[i-1];
            assign ay = c_ay_reg[i-1];
            assign aa = c_aa_reg[i-1];
            assign zx = c_zx_reg[i-1];
            assign zy = c_zy_reg[i-1];
            assign za = c_za_reg[i-1];
        end

        assign rom = c2s_pkg::atan_rom(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_valid_reg[i] <= 1'b0;
            else if (adv)
                c_valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_tag_reg[i] <= t_in;
                if (ay >= 0)
                begin
                    c_ax_reg[i] <= ax + (ay >>> i);
                    c_ay_reg[i] <= ay - (ax >>> i);
                    c_aa_reg[i] <= aa + rom;
                end
                else
                begin
                    c_ax_reg[i] <= ax - (ay >>> i);
                    c_ay_reg[i] <= ay + (ax >>> i);
                    c_aa_reg[i] <= aa - rom;
                end
                if (zy >= 0)
                begin
                    c_zx_reg[i] <= zx + (zy >>> i);
                    c_zy_reg[i] <= zy - (zx >>> i);
                    c_za_reg[i] <= za + rom;
                end
                else
                begin
                    c_zx_reg[i] <= zx - (zy >>> i);
                    c_zy_reg[i] <= zy + (zx >>> i);
                    c_za_reg[i] <= za - rom;
                end
            end
        end
    end

    // wrap, clamp, round to output units, then pick fixed answers
    logic signed [AW-1:0] a_wrap, e_clamp;
    logic [AW-1:0]        a_rnd, e_rnd, az_val;
    c2s_pkg::tag_t        t_last;

    always_comb
    begin
        t_last = c_tag_reg[CS-1];
        a_wrap = (c_aa_reg[CS-1] < 0) ? c_aa_reg[CS-1] + c2s_pkg::ACC_DEG360 : c_aa_reg[CS-1];
        if (c_za_reg[CS-1] < 0)
            e_clamp = '0;
        else if (c_za_reg[CS-1] > c2s_pkg::ACC_DEG180)
            e_clamp = c2s_pkg::ACC_DEG180;
        else
            e_clamp = c_za_reg[CS-1];
        a_rnd  = (AW'(unsigned'(a_wrap)) + c2s_pkg::ROUND_HALF) >> c2s_pkg::ROUND_SHIFT;
        e_rnd  = (AW'(unsigned'(e_clamp)) + c2s_pkg::ROUND_HALF) >> c2s_pkg::ROUND_SHIFT;
        az_val = (a_rnd >= c2s_pkg::OUT_DEG360) ? '0 : a_rnd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= c_valid_reg[CS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            az_reg  <= t_last.az_fix_v ? t_last.az_fix : az_val[c2s_pkg::AZ_W-1:0];
            zen_reg <= t_last.zen_fix_v ? t_last.zen_fix : e_rnd[c2s_pkg::ZEN_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && c_valid_reg[CS-1]) |=> out_valid_reg)
        else $error("finished word did not reach the output register");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(c_za_reg[CS-1]) && $stable(c_valid_reg[CS-1])))
        else $error("pipeline moved during a stall");
`endif

endmodule

// File: sv/cartesian_to_spherical_angles.sv
// top level of the spherical angle block: front stage, queue and angle pipeline
// Converts a signed 16-bit vector (vec_x, vec_y, vec_z) into azimuth in [0, 360)
// and zenith in [0, 180] degrees, both in units of 1/128 degree rounded to
// nearest. One vector word is taken per clock and one angle word leaves per
// clock as long as the sink keeps ready high; a word passes through one front
// register, one queue slot, then 63 pipeline stages: sum of squares,
// 5 normalize, 31 square root, cordic load, 24 cordic, output. The whole angle
// pipeline holds while the output word waits, and the queue in front of it
// keeps taking words until it fills. The axis cases and the zero vector give
// exact angles; the in-plane case gives a zenith of exactly 90.
module cartesian_to_spherical_angles (
    input  logic      clk,
    input  logic      rst_n,
    c2s_vec_if.sink   vec,
    c2s_ang_if.source angles
);

    // classified word from the front stage into the queue
    logic            push_valid;
    logic            push_ready;
    c2s_pkg::item_t  push_item;

    // head of the queue into the angle pipeline
    logic            pop_valid;
    logic            pop_ready;
    c2s_pkg::item_t  pop_item;

    // front: squares of x and y, axis and zero cases settled here
    c2s_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec        (vec),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue so the front keeps taking words while the back is stalled
    c2s_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: radius, square root, two cordic lanes and rounding
    c2s_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .angles    (angles)
    );

endmodule
